@@ design/kst_pkg.sv @@
package kst_pkg;

	// Widths of the word fields.
	localparam int CODE_W = 8;
	localparam int KEY_W  = 7;
	localparam int CMD_W  = 2;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_RAW   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TAKE  = 2'd2;

	// Prefix tracking state.
	localparam logic [1:0] MODE_NONE = 2'd0;
	localparam logic [1:0] MODE_E0   = 2'd1;
	localparam logic [1:0] MODE_E1E2 = 2'd2;

	// Scan byte constants.
	localparam logic [CODE_W-1:0] CODE_E0 = 8'hE0;
	localparam logic [CODE_W-1:0] CODE_E1 = 8'hE1;
	localparam logic [CODE_W-1:0] CODE_E2 = 8'hE2;

	// One write into a key map.
	typedef struct packed {
		logic             en;
		logic [KEY_W-1:0] key;
		logic             down;
	} kst_wr_t;

endpackage

@@ design/kst_key_map.sv @@
module kst_key_map #(
	parameter int NUM_KEYS = 96
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  kst_pkg::kst_wr_t         wr,
	input  logic [kst_pkg::KEY_W-1:0] rd_key,
	output logic                     rd_down
);
	import kst_pkg::*;

	localparam int IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

	logic [NUM_KEYS-1:0] map_q;
	logic                wr_ok;
	logic                rd_ok;

	// Keys at or beyond the map size are neither stored nor read.
	assign wr_ok = ({1'b0, wr.key} < (KEY_W+1)'(NUM_KEYS));
	assign rd_ok = ({1'b0, rd_key} < (KEY_W+1)'(NUM_KEYS));

	// One flip-flop per key, cleared by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q <= '0;
		end else if (wr.en && wr_ok) begin
			map_q[wr.key[IDX_W-1:0]] <= wr.down;
		end
	end

	// Read returns zero for a key out of range.
	assign rd_down = rd_ok ? map_q[rd_key[IDX_W-1:0]] : 1'b0;

endmodule

@@ design/keyboard_scancode_key_tracker.sv @@
// Pipeline: an accepted input word is held in the input register, and its result
// is then written to the result register once that register is free or being drained.
// Throughput: one word per cycle while out_ready is high; with a result waiting, one more word is held.
// Reset (arst_n low, asynchronous): both key maps, the prefix state, the recent key
// and its flag clear to zero, and both pipeline registers empty.
module keyboard_scancode_key_tracker #(
	parameter int NUM_KEYS = 96
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [kst_pkg::CMD_W-1:0]  cmd,
	input  logic [kst_pkg::CODE_W-1:0] raw_code,
	input  logic [kst_pkg::KEY_W-1:0]  key_index,
	input  logic                       query_extended,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       key_down,
	output logic                       recent_available,
	output logic [kst_pkg::KEY_W-1:0]  recent_key
);
	import kst_pkg::*;

	// Input register.
	logic              valid_s1;
	logic [CMD_W-1:0]  cmd_s1;
	logic [CODE_W-1:0] code_s1;
	logic [KEY_W-1:0]  index_s1;
	logic              ext_s1;

	// Tracker state.
	logic [1:0]        prefix_q;
	logic              flag_q;
	logic [KEY_W-1:0]  last_q;

	// Result register.
	logic              out_valid_q;
	logic              key_down_q;
	logic              avail_q;
	logic [KEY_W-1:0]  recent_q;

	logic              advance;
	logic              byte_down;
	logic [KEY_W-1:0]  byte_key;
	logic              key_ok;
	logic              plain_rd;
	logic              ext_rd;
	logic [KEY_W-1:0]  plain_rd_key;
	kst_wr_t           plain_wr;
	kst_wr_t           ext_wr;
	logic [1:0]        prefix_next;
	logic              flag_next;
	logic [KEY_W-1:0]  last_next;
	logic              down_next;
	logic              avail_next;

	// The held word moves on when the result register is free or being drained.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1   <= cmd;
			code_s1  <= raw_code;
			index_s1 <= key_index;
			ext_s1   <= query_extended;
		end
	end

	// Split the scan byte into release bit and key number.
	assign byte_down = ~code_s1[CODE_W-1];
	assign byte_key  = code_s1[KEY_W-1:0];
	assign key_ok    = ({1'b0, byte_key} < (KEY_W+1)'(NUM_KEYS));

	// The plain map is read at the query key or at the scan byte key.
	assign plain_rd_key = (cmd_s1 == CMD_QUERY) ? index_s1 : byte_key;

	kst_key_map #(
		.NUM_KEYS(NUM_KEYS)
	) u_plain_map (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (plain_wr),
		.rd_key (plain_rd_key),
		.rd_down(plain_rd)
	);

	kst_key_map #(
		.NUM_KEYS(NUM_KEYS)
	) u_ext_map (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (ext_wr),
		.rd_key (index_s1),
		.rd_down(ext_rd)
	);

	// Decode the held word into state updates and the result.
	always_comb begin
		prefix_next   = prefix_q;
		flag_next     = flag_q;
		last_next     = last_q;
		plain_wr.en   = 1'b0;
		plain_wr.key  = byte_key;
		plain_wr.down = byte_down;
		ext_wr.en     = 1'b0;
		ext_wr.key    = byte_key;
		ext_wr.down   = byte_down;
		down_next     = 1'b0;
		avail_next    = flag_q;

		if (cmd_s1 == CMD_RAW) begin
			priority if (prefix_q == MODE_E0) begin
				ext_wr.en   = advance;
				prefix_next = MODE_NONE;
			end else if (prefix_q == MODE_E1E2) begin
				prefix_next = MODE_NONE;
			end else if (code_s1 == CODE_E0) begin
				prefix_next = MODE_E0;
			end else if (code_s1 == CODE_E1 || code_s1 == CODE_E2) begin
				prefix_next = MODE_E1E2;
			end else begin
				plain_wr.en = advance;
				if (key_ok && byte_down && !plain_rd) begin
					flag_next = 1'b1;
					last_next = byte_key;
				end
			end
			avail_next = flag_next;
		end else if (cmd_s1 == CMD_QUERY) begin
			down_next = ext_s1 ? ext_rd : plain_rd;
		end else if (cmd_s1 == CMD_TAKE) begin
			flag_next = 1'b0;
		end
	end

	// Tracker state updates only when the word is consumed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q <= MODE_NONE;
			flag_q   <= 1'b0;
			last_q   <= '0;
		end else if (advance) begin
			prefix_q <= prefix_next;
			flag_q   <= flag_next;
			last_q   <= last_next;
		end
	end

	// Map writes are gated by the same advance.

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			key_down_q <= down_next;
			avail_q    <= avail_next;
			recent_q   <= last_next;
		end
	end

	assign out_valid        = out_valid_q;
	assign key_down         = key_down_q;
	assign recent_available = avail_q;
	assign recent_key       = recent_q;

endmodule

@@ tb/sv/keyboard_scancode_key_tracker_tb.sv @@
module keyboard_scancode_key_tracker_tb;

	import kst_pkg::*;

	localparam int NUM_KEYS = 96;
	localparam int RANDOM_WORDS = 450;
	localparam int LONG_HOLD = 80;
	localparam int IDLE_LIMIT = 1000;

	// The fourth command code is unused by the block and must change nothing.
	localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [CODE_W-1:0] raw_code;
		logic [KEY_W-1:0]  key_index;
		logic              query_ext;
	} scan_word_t;

	typedef struct packed {
		logic             key_down;
		logic             recent_avail;
		logic [KEY_W-1:0] recent_key;
	} key_result_t;

	typedef struct packed {
		scan_word_t  word;
		logic        typed;
		key_result_t want;
	} dir_row_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [CMD_W-1:0]  cmd;
	logic [CODE_W-1:0] raw_code;
	logic [KEY_W-1:0]  key_index;
	logic              query_extended;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic              key_down;
	logic              recent_available;
	logic [KEY_W-1:0]  recent_key;

	// Typed expectation that travels with the word currently offered.
	logic        drv_typed;
	key_result_t drv_want;

	// Shadow copy of the tracker state.
	logic [1:0]          pfx_state = MODE_NONE;
	logic [NUM_KEYS-1:0] plain_down = '0;
	logic [NUM_KEYS-1:0] ext_down = '0;
	logic [KEY_W-1:0]    recent_latched = '0;
	logic                recent_flag = 1'b0;

	key_result_t pending_results[$];
	scan_word_t  stim_q[$];
	int          mismatches = 0;
	int          idle_cycles = 0;
	int          burst_left = 0;
	int          holds_wanted = 0;
	int          holds_done = 0;
	int          hold_left = 0;
	int          rx_cycle = 0;

	// Directed words. Only the rows right after reset carry a typed result.
	dir_row_t dir_rows [28] = '{
		'{'{CMD_QUERY, 8'h00, 7'd0, 1'b0}, 1'b1, '{1'b0, 1'b0, 7'd0}},
		'{'{CMD_TAKE, 8'h00, 7'd0, 1'b0}, 1'b1, '{1'b0, 1'b0, 7'd0}},
		'{'{CMD_NONE, 8'hFF, 7'd127, 1'b1}, 1'b1, '{1'b0, 1'b0, 7'd0}},
		'{'{CMD_RAW, 8'h00, 7'd0, 1'b0}, 1'b0, '0},
		'{'{CMD_RAW, 8'h5F, 7'd0, 1'b0}, 1'b0, '0},
		'{'{CMD_RAW, 8'h5F, 7'd0, 1'b0}, 1'b0, '0},
		'{'{CMD_QUERY, 8'h00, 7'd95, 1'b0}, 1'b0, '0},
		'{'{CMD_QUERY, 8'h00, 7'd127, 1'b1}, 1'b0, '0},
		'{'{CMD_RAW, 8'h60, 7'd0, 1'b0}, 1'b0, '0},
		'{'{CMD_RAW, 8'hFF, 7'd0, 1'b0}, 1'b0, '0},
		'{'{CMD_TAKE, 8'h00, 7'd0, 1'b0}, 1'b0, '0},
		'{'{CMD_TAKE, 8'h00, 7'd0, 1'b0}, 1'b0, '0},
		'{'{CMD_RAW, CODE_E0, 7'd0, 1'b0}, 1'b0, '0},
		'{'{CMD_RAW, 8'h10, 7'd0, 1'b0}, 1'b0, '0},
		'{'{CMD_QUERY, 8'h00, 7'd16, 1'b1}, 1'b0, '0},
		'{'{CMD_RAW, CODE_E0, 7'd0, 1'b0}, 1'b0, '0},
		'{'{CMD_RAW, CODE_E1, 7'd0, 1'b0}, 1'b0, '0},
		'{'{CMD_RAW, 8'h05, 7'd0, 1'b0}, 1'b0, '0},
		'{'{CMD_RAW, CODE_E0, 7'd0, 1'b0}, 1'b0, '0},
		'{'{CMD_QUERY, 8'h00, 7'd16, 1'b1}, 1'b0, '0},
		'{'{CMD_RAW, 8'h90, 7'd0, 1'b0}, 1'b0, '0},
		'{'{CMD_RAW, CODE_E1, 7'd0, 1'b0}, 1'b0, '0},
		'{'{CMD_RAW, 8'h1E, 7'd0, 1'b0}, 1'b0, '0},
		'{'{CMD_RAW, CODE_E2, 7'd0, 1'b0}, 1'b0, '0},
		'{'{CMD_RAW, 8'h9E, 7'd0, 1'b0}, 1'b0, '0},
		'{'{CMD_RAW, 8'h80, 7'd0, 1'b0}, 1'b0, '0},
		'{'{CMD_RAW, 8'hDF, 7'd0, 1'b0}, 1'b0, '0},
		'{'{CMD_RAW, 8'h00, 7'd0, 1'b0}, 1'b0, '0}
	};

	keyboard_scancode_key_tracker #(
		.NUM_KEYS(NUM_KEYS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.raw_code(raw_code),
		.key_index(key_index),
		.query_extended(query_extended),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.key_down(key_down),
		.recent_available(recent_available),
		.recent_key(recent_key)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Apply one accepted word to the shadow state and return the result it causes.
	function automatic key_result_t track_word(scan_word_t w);
		key_result_t      res;
		logic             pressed;
		logic [KEY_W-1:0] key;
		res = '0;
		pressed = ~w.raw_code[7];
		key = w.raw_code[6:0];
		case (w.cmd)
			CMD_RAW: begin
				if (pfx_state == MODE_E0) begin
					// Any byte after E0 is a key code, even another prefix byte.
					if (key < NUM_KEYS)
						ext_down[key] = pressed;
					pfx_state = MODE_NONE;
				end else if (pfx_state == MODE_E1E2) begin
					pfx_state = MODE_NONE;
				end else if (w.raw_code == CODE_E0) begin
					pfx_state = MODE_E0;
				end else if (w.raw_code == CODE_E1 || w.raw_code == CODE_E2) begin
					pfx_state = MODE_E1E2;
				end else if (key < NUM_KEYS) begin
					// Only an up-to-down change of a plain key is latched.
					if (!plain_down[key] && pressed) begin
						recent_flag = 1'b1;
						recent_latched = key;
					end
					plain_down[key] = pressed;
				end
				res.recent_avail = recent_flag;
			end
			CMD_QUERY: begin
				if (w.key_index < NUM_KEYS)
					res.key_down = w.query_ext ? ext_down[w.key_index] : plain_down[w.key_index];
				res.recent_avail = recent_flag;
			end
			CMD_TAKE: begin
				res.recent_avail = recent_flag;
				recent_flag = 1'b0;
			end
			default: begin
				res.recent_avail = recent_flag;
			end
		endcase
		res.recent_key = recent_latched;
		return res;
	endfunction

	function automatic void report_field(string fname, int want, int got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
		end
	endfunction

	// Mostly a small pool of keys so presses, repeats and releases collide.
	function automatic logic [KEY_W-1:0] pick_key();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6)
			return KEY_W'($urandom_range(0, 11));
		if (r < 8)
			return KEY_W'($urandom_range(84, NUM_KEYS - 1));
		return KEY_W'($urandom_range(0, 127));
	endfunction

	function automatic scan_word_t raw_word(logic [CODE_W-1:0] code);
		scan_word_t w;
		w.cmd = CMD_RAW;
		w.raw_code = code;
		w.key_index = KEY_W'($urandom_range(0, 127));
		w.query_ext = 1'($urandom_range(0, 1));
		return w;
	endfunction

	// Queue one random sequence: a key event, an E0-prefixed event, an E1/E2 pair, or a query, take, unused or raw word.
	function automatic void push_sequence();
		int               r;
		logic             rel;
		logic [KEY_W-1:0] k;
		scan_word_t       w;
		r = $urandom_range(0, 99);
		rel = ($urandom_range(0, 9) < 4);
		k = pick_key();
		if (r < 35) begin
			stim_q.push_back(raw_word({rel, k}));
		end else if (r < 50) begin
			stim_q.push_back(raw_word(CODE_E0));
			stim_q.push_back(raw_word({rel, k}));
		end else if (r < 55) begin
			stim_q.push_back(raw_word($urandom_range(0, 1) ? CODE_E1 : CODE_E2));
			stim_q.push_back(raw_word(CODE_W'($urandom_range(0, 255))));
		end else begin
			w.raw_code = CODE_W'($urandom_range(0, 255));
			w.key_index = k;
			w.query_ext = 1'($urandom_range(0, 1));
			if (r < 70)
				w.cmd = CMD_QUERY;
			else if (r < 80)
				w.cmd = CMD_TAKE;
			else if (r < 84)
				w.cmd = CMD_NONE;
			else
				w.cmd = CMD_RAW;
			stim_q.push_back(w);
		end
	endfunction

	// Offer one word, in bursts of random length with random gaps between them.
	task automatic send_word(input scan_word_t w, input logic typed, input key_result_t want);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		cmd <= w.cmd;
		raw_code <= w.raw_code;
		key_index <= w.key_index;
		query_extended <= w.query_ext;
		drv_typed <= typed;
		drv_want <= want;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Stop offering until every outstanding result word has come back.
	// The queue is checked at falling edges, after the monitor has run.
	task automatic wait_all_results();
		in_valid <= 1'b0;
		burst_left = 0;
		@(negedge clk);
		while (pending_results.size() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	// Receiver: rotating stall patterns, plus a long hold-off on request.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (holds_done != holds_wanted) begin
			holds_done <= holds_wanted;
			hold_left <= LONG_HOLD;
			out_ready <= 1'b0;
		end else begin
			rx_cycle <= rx_cycle + 1;
			case ((rx_cycle / 48) % 4)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 3) != 0);
				2: out_ready <= ($urandom_range(0, 1) == 0);
				default: out_ready <= (rx_cycle % 5 == 0);
			endcase
		end
	end

	// Predict on every accepted input word, check every accepted result word,
	// and end the run if neither channel moves for too long.
	always @(posedge clk) begin
		key_result_t res;
		key_result_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				res = track_word(scan_word_t'{cmd, raw_code, key_index, query_extended});
				pending_results.push_back(drv_typed ? drv_want : res);
			end
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					mismatches++;
					$display("%0t: result word with none expected, actual %0d %0d %0d",
						$time, key_down, recent_available, recent_key);
				end else begin
					want = pending_results.pop_front();
					report_field("key_down", want.key_down, key_down);
					report_field("recent_available", want.recent_avail, recent_available);
					report_field("recent_key", want.recent_key, recent_key);
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		int sent;
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = CMD_RAW;
		raw_code = '0;
		key_index = '0;
		query_extended = 1'b0;
		drv_typed = 1'b0;
		drv_want = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);
		wait_all_results();

		// Random part; one long receiver hold-off and one full drain midway.
		sent = 0;
		while (sent < RANDOM_WORDS) begin
			push_sequence();
			while (stim_q.size() != 0) begin
				send_word(stim_q.pop_front(), 1'b0, '0);
				sent++;
				if (sent == 150)
					holds_wanted++;
				if (sent == 300)
					wait_all_results();
			end
		end

		wait_all_results();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
